FILE: rtl/mfd_pkg.sv
// Shared types and constants for the motor feedback multi-turn decoder.
`timescale 1ns / 1ps
`default_nettype none
package mfd_pkg;

	localparam int unsigned ONE_Q15 = 32768;
	localparam int unsigned ADDR_W  = 4;
	localparam int unsigned MUL_A_W = 17;
	localparam int unsigned MUL_B_W = 32;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	typedef enum logic [1:0] {
		REG_SPEED_ALPHA   = 2'd0,
		REG_CURRENT_ALPHA = 2'd1,
		REG_SPEED_GAIN    = 2'd2
	} reg_idx_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_GAIN = 7'b0000010,
		ST_SOLD = 7'b0000100,
		ST_SNEW = 7'b0001000,
		ST_COLD = 7'b0010000,
		ST_CNEW = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/mfd_in_if.sv
// Feedback frame channel: valid, ready and the unpacked frame fields.
`timescale 1ns / 1ps
`default_nettype none
interface mfd_in_if;
	logic               valid;
	logic               ready;
	logic        [12:0] encoder;
	logic signed [15:0] speed_rpm;
	logic signed [15:0] current_raw;
	logic        [7:0]  temperature;

	modport source (output valid, encoder, speed_rpm, current_raw, temperature, input ready);
	modport sink (input valid, encoder, speed_rpm, current_raw, temperature, output ready);
endinterface
`default_nettype wire

FILE: rtl/mfd_out_if.sv
// Decoded result channel: valid, ready and the angle, speed and current fields.
`timescale 1ns / 1ps
`default_nettype none
interface mfd_out_if;
	logic               valid;
	logic               ready;
	logic        [18:0] angle_in_turn;
	logic signed [42:0] abs_angle;
	logic signed [23:0] turns;
	logic signed [31:0] speed_dps;
	logic signed [23:0] current_avg;
	logic        [7:0]  temp_out;

	modport source (output valid, angle_in_turn, abs_angle, turns, speed_dps, current_avg,
		temp_out, input ready);
	modport sink (input valid, angle_in_turn, abs_angle, turns, speed_dps, current_avg,
		temp_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/motor_feedback_multi_turn_decoder_unit.sv
// Motor feedback decoder: multi-turn angle tracking with speed and current smoothing.
//
// Usage:
//   frame  : valid/ready channel of unpacked feedback frames (encoder, rpm,
//            current, temperature). A beat is taken only while the decoder is idle.
//   result : valid/ready channel with one beat per frame: in-turn angle, total
//            angle (degrees Q10), turn count, smoothed speed and current (Q8)
//            and the temperature byte.
//   APB    : three 16-bit registers at byte addresses 0, 4, 8 (speed weight,
//            current weight, speed gain); write only while idle.
// Timing: a frame accepted in IDLE steps through GAIN, SOLD, SNEW, COLD, CNEW
//   and FIN, and the next frame can be taken only once the state is back in
//   IDLE, so one frame is finished before the next is taken. The steps are
//   five passes through the one shared 17x32 multiplier plus the final accumulate.
// Reset: arst_n clears the turn count, last position and both filters, and
//   loads the register defaults. No result is pending after reset.
// Stall: a result waits in the output register; the next frame is still
//   accepted and processed, and holds in its last step until the output frees.
`timescale 1ns / 1ps
`default_nettype none
module motor_feedback_multi_turn_decoder_unit
	import mfd_pkg::*;
#(
	parameter int TURN_BITS = 24,
	parameter int HALF_TURN = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	mfd_in_if.sink                 frame,
	mfd_out_if.source              result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam logic signed [17:0] HalfS = 18'(HALF_TURN);

	state_t state_q;

	logic        [15:0] spd_alpha_q;
	logic        [15:0] cur_alpha_q;
	logic        [15:0] gain_q;

	logic        [12:0] enc_q;
	logic signed [15:0] rpm_q;
	logic signed [15:0] cur_q;
	logic        [7:0]  temp_q;
	logic        [12:0] last_pos_q;
	logic [TURN_BITS-1:0] turn_q;
	logic signed [31:0] spd_q;
	logic signed [23:0] curf_q;
	logic signed [31:0] sample_q;
	logic signed [MUL_P_W-1:0] acc_q;
	logic        [42:0] tot_q;

	logic               out_valid_q;
	logic        [18:0] angle_q;
	logic        [42:0] total_q;
	logic        [23:0] turns_q;
	logic        [31:0] speed_q;
	logic        [23:0] curavg_q;
	logic        [7:0]  tempo_q;

	logic               accept;
	logic               out_free;
	logic               cfg_wr;
	logic signed [13:0] diff;
	logic signed [17:0] diff_w;
	logic [TURN_BITS-1:0] turn_next;
	logic signed [63:0] turn_ext;
	logic        [42:0] tot_x;
	logic        [15:0] wa;
	logic        [15:0] wc;
	logic               mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;
	logic signed [MUL_P_W-1:0] sum;
	logic        [18:0] angle_next;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign frame.ready = (state_q == ST_IDLE);
	assign accept   = frame.valid && frame.ready;
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_SPEED_ALPHA:   prdata = {16'h0, spd_alpha_q};
			REG_CURRENT_ALPHA: prdata = {16'h0, cur_alpha_q};
			REG_SPEED_GAIN:    prdata = {16'h0, gain_q};
			default:           prdata = 32'h0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_alpha_q <= 16'd27853;
			cur_alpha_q <= 16'd29491;
			gain_q      <= 16'd1536;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_SPEED_ALPHA:   spd_alpha_q <= pwdata[15:0];
				REG_CURRENT_ALPHA: cur_alpha_q <= pwdata[15:0];
				REG_SPEED_GAIN:    gain_q      <= pwdata[15:0];
				default:           ;
			endcase
		end
	end

	// wrap detection against the stored position
	assign diff   = $signed({1'b0, frame.encoder}) - $signed({1'b0, last_pos_q});
	assign diff_w = 18'(diff);
	always_comb begin
		if (diff_w > HalfS) begin
			turn_next = turn_q - TURN_BITS'(1);
		end else if (diff_w < -HalfS) begin
			turn_next = turn_q + TURN_BITS'(1);
		end else begin
			turn_next = turn_q;
		end
	end

	assign turn_ext = 64'($signed(turn_q));
	// turns * 8192 + encoder, later times 45 gives turns * 368640 + encoder * 45
	assign tot_x      = {turn_ext[29:0], enc_q};
	assign angle_next = 19'(enc_q) * 19'd45;

	assign wa = (spd_alpha_q > 16'(ONE_Q15)) ? 16'(ONE_Q15) : spd_alpha_q;
	assign wc = (cur_alpha_q > 16'(ONE_Q15)) ? 16'(ONE_Q15) : cur_alpha_q;

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_GAIN: begin
				mul_a = $signed({1'b0, gain_q});
				mul_b = 32'(rpm_q);
			end
			ST_SOLD: begin
				mul_a = $signed(17'(ONE_Q15) - {1'b0, wa});
				mul_b = spd_q;
			end
			ST_SNEW: begin
				mul_a = $signed({1'b0, wa});
				mul_b = sample_q;
			end
			ST_COLD: begin
				mul_a = $signed(17'(ONE_Q15) - {1'b0, wc});
				mul_b = 32'(curf_q);
			end
			ST_CNEW: begin
				mul_a = $signed({1'b0, wc});
				mul_b = 32'($signed({cur_q, 8'h00}));
			end
			default: mul_en = 1'b0;
		endcase
	end

	mfd_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// floor of the Q15 division is the slice of the two's complement sum
	assign sum = acc_q + prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			last_pos_q <= '0;
			turn_q     <= '0;
			spd_q      <= '0;
			curf_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_pos_q <= frame.encoder;
						turn_q     <= turn_next;
						state_q    <= ST_GAIN;
					end
				end
				ST_GAIN: state_q <= ST_SOLD;
				ST_SOLD: state_q <= ST_SNEW;
				ST_SNEW: state_q <= ST_COLD;
				ST_COLD: begin
					spd_q   <= sum[46:15];
					state_q <= ST_CNEW;
				end
				ST_CNEW: state_q <= ST_FIN;
				ST_FIN: begin
					// hold until the output register frees
					if (out_free) begin
						curf_q      <= sum[38:15];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			enc_q  <= frame.encoder;
			rpm_q  <= frame.speed_rpm;
			cur_q  <= frame.current_raw;
			temp_q <= frame.temperature;
		end
		case (state_q)
			ST_GAIN: tot_q <= tot_x + (tot_x << 3);
			ST_SOLD: begin
				sample_q <= prod[31:0];
				tot_q    <= tot_q + (tot_q << 2);
			end
			ST_SNEW: acc_q <= prod;
			ST_CNEW: acc_q <= prod;
			ST_FIN: begin
				if (out_free) begin
					angle_q  <= angle_next;
					total_q  <= tot_q;
					turns_q  <= turn_ext[23:0];
					speed_q  <= spd_q;
					curavg_q <= sum[38:15];
					tempo_q  <= temp_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid         = out_valid_q;
	assign result.angle_in_turn = angle_q;
	assign result.abs_angle     = $signed(total_q);
	assign result.turns         = $signed(turns_q);
	assign result.speed_dps     = $signed(speed_q);
	assign result.current_avg   = $signed(curavg_q);
	assign result.temp_out      = tempo_q;

`ifndef NO_ASSERTIONS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_GAIN))
		else $error("accepted frame did not start the sequence");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && result.valid && !result.ready) |=> (state_q == ST_FIN))
		else $error("result overwritten while stalled");

	a_turn_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (turn_q == $past(turn_q) || turn_q == $past(turn_q) + TURN_BITS'(1) ||
			turn_q == $past(turn_q) - TURN_BITS'(1)))
		else $error("turn count moved by more than one");

	a_turn_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(turn_q))
		else $error("turn count changed without a frame");
`endif

endmodule
`default_nettype wire

FILE: rtl/mfd_mul.sv
// Shared signed 17x32 multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module mfd_mul
	import mfd_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0]      prod
);

	logic signed [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the motor feedback multi-turn decoder.
`timescale 1ns / 1ps
module testbench
	import mfd_pkg::*;
;

	localparam int     HALF_TURN_COUNTS  = 4096;
	localparam longint TURN_Q10          = 368640;
	localparam int     DEG_Q10_PER_COUNT = 45;
	localparam longint WEIGHT_ONE        = 32768;
	localparam int     DRAIN_CYCLES      = 12;
	localparam int     HOLD_OFF_CYCLES   = 400;
	localparam int     RANDOM_PHASES     = 6;
	localparam int     FRAMES_PER_PHASE  = 155;
	localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(12);

	typedef struct {
		logic        [12:0] encoder;
		logic signed [15:0] speed_rpm;
		logic signed [15:0] current_raw;
		logic        [7:0]  temperature;
	} frame_t;

	typedef struct {
		logic [18:0] angle_in_turn;
		logic [42:0] abs_angle;
		logic [23:0] turns;
		logic [31:0] speed_dps;
		logic [23:0] current_avg;
		logic [7:0]  temp_out;
	} decoded_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	mfd_in_if  frame_if ();
	mfd_out_if result_if ();

	motor_feedback_multi_turn_decoder_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// tracker state and register copies
	logic [12:0] last_pos;
	logic [23:0] turn_cnt;
	longint      speed_avg_q8;
	longint      current_avg_q8;
	logic [15:0] speed_weight;
	logic [15:0] current_weight;
	logic [15:0] speed_gain;

	frame_t   frames_to_send[$];
	decoded_t decoded_due[$];
	frame_t   next_frame;
	frame_t   seen_frame;
	decoded_t want;

	logic frame_taken = 1'b0;
	logic idle_on     = 1'b1;
	int   frame_gap   = 0;
	int   stall_left  = 0;
	int   next_hold_at = 100;
	int   walk_pos    = 0;
	int   walk_dir    = 1;
	int   mismatches  = 0;
	int   frames_sent = 0;
	int   decoded_seen = 0;
	int   settings_used = 1;
	int   turns_lo    = 0;
	int   turns_hi    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint smooth_q15(longint old, longint sample, logic [15:0] w);
		longint wt;
		wt = (w > 16'd32768) ? WEIGHT_ONE : longint'(w);
		return ((WEIGHT_ONE - wt) * old + wt * sample) >>> 15;
	endfunction

	function automatic decoded_t track_frame(frame_t f);
		decoded_t d;
		int diff;
		logic signed [23:0] turns_s;
		longint total;
		diff = int'(f.encoder) - int'(last_pos);
		if (diff > HALF_TURN_COUNTS) begin
			turn_cnt = turn_cnt - 24'd1;
		end else if (diff < -HALF_TURN_COUNTS) begin
			turn_cnt = turn_cnt + 24'd1;
		end
		last_pos = f.encoder;
		speed_avg_q8 = smooth_q15(speed_avg_q8,
			longint'(f.speed_rpm) * longint'(speed_gain), speed_weight);
		current_avg_q8 = smooth_q15(current_avg_q8, longint'(f.current_raw) * 256,
			current_weight);
		turns_s = turn_cnt;
		if (int'(turns_s) < turns_lo) turns_lo = int'(turns_s);
		if (int'(turns_s) > turns_hi) turns_hi = int'(turns_s);
		d.angle_in_turn = f.encoder * 19'(DEG_Q10_PER_COUNT);
		total = longint'(turns_s) * TURN_Q10 + longint'(d.angle_in_turn);
		d.abs_angle = total[42:0];
		d.turns = turn_cnt;
		d.speed_dps = speed_avg_q8[31:0];
		d.current_avg = current_avg_q8[23:0];
		d.temp_out = f.temperature;
		return d;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly a rotating shaft that wraps often, with jumps and edge positions mixed in
	function automatic frame_t random_frame();
		frame_t f;
		int r;
		int step;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			if ($urandom_range(0, 19) == 0) walk_dir = -walk_dir;
			if ($urandom_range(0, 9) == 0) step = $urandom_range(4090, 4100);
			else step = $urandom_range(0, 1800);
			walk_pos = (walk_pos + walk_dir * step) & 8191;
		end else if (r < 85) begin
			walk_pos = $urandom_range(0, 8191);
		end else begin
			case ($urandom_range(0, 4))
				0: walk_pos = 0;
				1: walk_pos = 8191;
				2: walk_pos = 4095;
				3: walk_pos = 4096;
				default: walk_pos = 4097;
			endcase
		end
		f.encoder = walk_pos[12:0];
		f.speed_rpm = pick_sample();
		f.current_raw = pick_sample();
		f.temperature = 8'($urandom);
		return f;
	endfunction

	function automatic void check_field(string name, logic [63:0] expected, logic [63:0] actual);
		if (expected !== actual) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, expected, actual);
			mismatches++;
		end
	endfunction

	function automatic logic [ADDR_W-1:0] reg_addr(reg_idx_t idx);
		return ADDR_W'(idx) << 2;
	endfunction

	task automatic queue_frame(int enc, int rpm, int cur, int temp);
		frame_t f;
		f.encoder = enc[12:0];
		f.speed_rpm = rpm[15:0];
		f.current_raw = cur[15:0];
		f.temperature = temp[7:0];
		frames_to_send.push_back(f);
	endtask

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [15:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {16'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr[ADDR_W-1:2])
			REG_SPEED_ALPHA: speed_weight = value;
			REG_CURRENT_ALPHA: current_weight = value;
			REG_SPEED_GAIN: speed_gain = value;
			default: ;
		endcase
	endtask

	task automatic write_settings(logic [15:0] s_alpha, logic [15:0] c_alpha,
		logic [15:0] gain);
		reg_write(reg_addr(REG_SPEED_ALPHA), s_alpha);
		reg_write(reg_addr(REG_CURRENT_ALPHA), c_alpha);
		reg_write(reg_addr(REG_SPEED_GAIN), gain);
		settings_used++;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (frames_to_send.size() != 0 || frame_if.valid || decoded_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// frame driver
	always @(negedge clk) begin
		if (arst_n && (!frame_if.valid || frame_taken)) begin
			if (frame_gap > 0) begin
				frame_gap <= frame_gap - 1;
				frame_if.valid <= 1'b0;
			end else if (frames_to_send.size() != 0) begin
				next_frame = frames_to_send.pop_front();
				frame_if.encoder <= next_frame.encoder;
				frame_if.speed_rpm <= next_frame.speed_rpm;
				frame_if.current_raw <= next_frame.current_raw;
				frame_if.temperature <= next_frame.temperature;
				frame_if.valid <= 1'b1;
				frame_gap <= (idle_on && $urandom_range(0, 1)) ? pick_gap() : 0;
			end else begin
				frame_if.valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls plus long hold-offs to back up the frame side
	always @(negedge clk) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			result_if.ready <= 1'b0;
		end else if (decoded_seen >= next_hold_at) begin
			next_hold_at = next_hold_at + 500;
			stall_left = HOLD_OFF_CYCLES;
			result_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 99) < 30) begin
			stall_left = pick_gap() - 1;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= 1'b1;
		end
	end

	// monitor: check results first, then predict the frame taken at this edge
	always @(posedge clk) begin
		frame_taken <= arst_n && frame_if.valid && frame_if.ready;
		if (arst_n && result_if.valid && result_if.ready) begin
			decoded_seen++;
			if (decoded_due.size() == 0) begin
				$error("result beat with no frame pending");
				mismatches++;
			end else begin
				want = decoded_due.pop_front();
				check_field("angle_in_turn", 64'(want.angle_in_turn), 64'(result_if.angle_in_turn));
				check_field("abs_angle", 64'(want.abs_angle),
					64'($unsigned(result_if.abs_angle)));
				check_field("turns", 64'(want.turns), 64'($unsigned(result_if.turns)));
				check_field("speed_dps", 64'(want.speed_dps),
					64'($unsigned(result_if.speed_dps)));
				check_field("current_avg", 64'(want.current_avg),
					64'($unsigned(result_if.current_avg)));
				check_field("temp_out", 64'(want.temp_out), 64'(result_if.temp_out));
			end
		end
		if (arst_n && frame_if.valid && frame_if.ready) begin
			seen_frame.encoder = frame_if.encoder;
			seen_frame.speed_rpm = frame_if.speed_rpm;
			seen_frame.current_raw = frame_if.current_raw;
			seen_frame.temperature = frame_if.temperature;
			decoded_due.push_back(track_frame(seen_frame));
			frames_sent++;
		end
	end

	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		frame_if.valid = 1'b0;
		frame_if.encoder = '0;
		frame_if.speed_rpm = '0;
		frame_if.current_raw = '0;
		frame_if.temperature = '0;
		result_if.ready = 1'b0;
		last_pos = '0;
		turn_cnt = '0;
		speed_avg_q8 = 0;
		current_avg_q8 = 0;
		speed_weight = 16'd27853;
		current_weight = 16'd29491;
		speed_gain = 16'd1536;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// turn counting around the half-turn threshold, default weights
		queue_frame(8191, 32767, 32767, 255);
		queue_frame(0, -32768, -32768, 0);
		queue_frame(4096, 0, 0, 'h55);
		queue_frame(0, -1, -1, 'haa);
		queue_frame(4097, 1, 1, 1);
		queue_frame(0, 100, -100, 2);
		queue_frame(4095, 32767, -32768, 3);
		queue_frame(8191, -32768, 32767, 4);
		queue_frame(0, 0, 0, 5);
		wait_drained();

		// weight above one clamps, full gain
		write_settings(16'hffff, 16'd32768, 16'hffff);
		queue_frame(1, 32767, 32767, 6);
		queue_frame(2, -32768, -32768, 7);
		queue_frame(3, 32767, -32768, 8);
		queue_frame(4, -32768, 32767, 9);
		wait_drained();

		// zero weights hold the filters, zero gain
		write_settings(16'd0, 16'd0, 16'd0);
		queue_frame(5000, 32767, 32767, 10);
		queue_frame(8000, -32768, -32768, 11);
		wait_drained();

		// a write past the last register must change nothing
		reg_write(SPARE_ADDR, 16'hffff);
		@(posedge clk);
		queue_frame(100, 1234, -4321, 12);
		wait_drained();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			idle_on = (phase != 2);
			case (phase)
				0: write_settings(16'($urandom_range(1, 32767)), 16'($urandom_range(1, 32767)),
					16'($urandom));
				1: write_settings(16'd32768, 16'hffff, 16'hffff);
				2: write_settings(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
					16'($urandom));
				3: write_settings(16'($urandom_range(32769, 65535)), 16'd1, 16'd1);
				4: write_settings(16'd27853, 16'd29491, 16'd1536);
				default: write_settings(16'd0, 16'($urandom_range(0, 32768)), 16'($urandom));
			endcase
			if (phase == 2) begin
				reg_write(SPARE_ADDR, 16'($urandom));
				@(posedge clk);
			end
			repeat (FRAMES_PER_PHASE) frames_to_send.push_back(random_frame());
			wait_drained();
		end

		$display("Decoded %0d frames (%0d results checked) across %0d register settings,",
			frames_sent, decoded_seen, settings_used);
		$display("with the turn count spanning %0d to %0d and two long result hold-offs.",
			turns_lo, turns_hi);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
